// ===== design/spsch_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spsch_pkg;

   // field widths fixed by the item format
   localparam int WIDTH_W = 16;
   localparam int UNIT_W  = 8;
   localparam int COUNT_W = 16;
   localparam int PIN_OUT_W = 16;
   localparam int PCH_OUT_W = 4;

   // request codes
   localparam logic [1:0] REQ_SLOT = 2'd0;
   localparam logic [1:0] REQ_EXP0 = 2'd1;
   localparam logic [1:0] REQ_EXP1 = 2'd2;
   localparam logic [1:0] REQ_SET  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SKIP     = 2'd1;
   localparam logic [1:0] STATUS_IDLE_EXP = 2'd2;

   // register indexes on the csr port
   localparam logic REG_SLOT_UNIT = 1'b0;
   localparam logic REG_COUNTDOWN = 1'b1;

   // reset values of the registers
   localparam logic [UNIT_W-1:0]  SLOT_UNIT_RESET = 8'd100;
   localparam logic [COUNT_W-1:0] COUNTDOWN_RESET = 16'd1;

   // one channel's settings as held in the channel memory
   typedef struct packed {
      logic               enable;
      logic [WIDTH_W-1:0] width;
      logic [COUNT_W-1:0] countdown;
   } chan_word_type;

   // divider start request
   typedef struct packed {
      logic               start;
      logic [WIDTH_W-1:0] dividend;
      logic [UNIT_W-1:0]  divisor;
   } div_request_type;

   // divider result, held until the next start
   typedef struct packed {
      logic               done;
      logic [WIDTH_W-1:0] quotient;
      logic [UNIT_W-1:0]  remainder;
   } div_result_type;

endpackage

`default_nettype wire

// ===== design/spsch_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsch_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire spsch_pkg::div_request_type div_req,
   output spsch_pkg::div_result_type       div_res
);
   import spsch_pkg::*;

   localparam int STEP_W = $clog2(WIDTH_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WIDTH_W-1:0]  quo_ff, quo_in;
   logic [UNIT_W-1:0]   rem_ff, rem_in;
   logic [UNIT_W-1:0]   divisor_ff, divisor_in;

   // one restoring step per cycle, quotient shifts in where the dividend shifts out
   always_comb begin
      logic [UNIT_W:0] trial;
      logic [UNIT_W:0] diff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[WIDTH_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[UNIT_W-1:0];
            quo_in = {quo_ff[WIDTH_W-2:0], 1'b1};
         end else begin
            rem_in = trial[UNIT_W-1:0];
            quo_in = {quo_ff[WIDTH_W-2:0], 1'b0};
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(WIDTH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_res.done      = done_ff;
   assign div_res.quotient  = quo_ff;
   assign div_res.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/spsch_chan_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsch_chan_mem #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output spsch_pkg::chan_word_type           rd_data,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire spsch_pkg::chan_word_type      wr_data
);
   import spsch_pkg::*;

   chan_word_type mem [DEPTH];
   logic          valid_ff [DEPTH];
   chan_word_type rd_word_ff;
   logic          rd_valid_ff;

   // entry valid bits, cleared at reset so unwritten channels read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// ===== design/servo_pulse_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Servo pulse scheduler: round-robin frame countdown per channel and two pulse engines.
// Input channel (req_*): one item per transfer, valid/stall. A slot tick serves the
// next channel, an engine expiry ends or rearms that engine's pulse, a set-channel item
// writes one channel's enable, width and countdown.
// Result channel (rsp_*): exactly one result per item, held in an output register
// until the receiver drops rsp_stall; a stalled result does not change.
// Set-channel and expiry items are answered straight from the latched request; a slot
// tick reads the served channel from the channel memory and, when it starts a pulse,
// waits on the bit-serial divider that splits the pulse width into slot units, one
// quotient bit per divider step, before the result is loaded.
// One item is in flight at a time; req_stall is high from transfer until the result
// is loaded, so a new item is taken only once the last one's result is loaded.
// If the receiver stalls, the finished item waits inside until the output register
// frees up.
// Csr port: slot_unit at address 0, countdown_reload at address 4; write while idle.
// Reset (synchronous): channels disabled with zero width and countdown, engines idle,
// pins low, serve position at channel 0, registers at 100 and 1; no clearing pass.

module servo_pulse_scheduler #(
   parameter int CHANNELS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [3:0]  req_channel,
   input  wire logic        req_enable,
   input  wire logic [15:0] req_pulse_width,
   input  wire logic [15:0] req_start_countdown,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pin_levels,
   output logic             rsp_arm_valid,
   output logic             rsp_arm_engine,
   output logic [7:0]       rsp_reload_value,
   output logic [3:0]       rsp_pulse_channel,
   output logic [1:0]       rsp_status,
   // csr port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import spsch_pkg::*;

   localparam int CH_W   = $clog2(CHANNELS > 1 ? CHANNELS : 2);
   localparam int PIN_W  = CHANNELS > PIN_OUT_W ? CHANNELS : PIN_OUT_W;
   localparam int PCH_W  = CH_W > PCH_OUT_W ? CH_W : PCH_OUT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_START,
      ST_EXEC
   } state_type;

   state_type           state_ff, state_in;

   // configuration registers
   logic [UNIT_W-1:0]   slot_unit_ff;
   logic [COUNT_W-1:0]  countdown_reload_ff;
   logic [UNIT_W-1:0]   unit_eff;
   logic                csr_write;

   // latched request
   logic [1:0]          rq_type_ff, rq_type_in;
   logic [3:0]          rq_ch_ff, rq_ch_in;
   logic                rq_en_ff, rq_en_in;
   logic [WIDTH_W-1:0]  rq_width_ff, rq_width_in;
   logic [COUNT_W-1:0]  rq_cd_ff, rq_cd_in;

   // scheduler and engine state
   logic [CH_W-1:0]     serve_ff, serve_in;
   logic [1:0]          eng_busy_ff, eng_busy_in;
   logic [CH_W-1:0]     eng_ch_ff [2];
   logic [CH_W-1:0]     eng_ch_in [2];
   logic [WIDTH_W-1:0]  eng_slots_ff [2];
   logic [WIDTH_W-1:0]  eng_slots_in [2];
   logic [CHANNELS-1:0] pin_ff, pin_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_pin_ff, rsp_pin_in;
   logic                rsp_arm_ff, rsp_arm_in;
   logic                rsp_eng_ff, rsp_eng_in;
   logic [7:0]          rsp_reload_ff, rsp_reload_in;
   logic [3:0]          rsp_pch_ff, rsp_pch_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   // shared units
   logic                accept;
   logic                out_free;
   chan_word_type       rd_word;
   logic                wr_en;
   logic [CH_W-1:0]     wr_addr;
   chan_word_type       wr_data;
   div_request_type     div_req;
   div_result_type      div_res;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign unit_eff = (slot_unit_ff == '0) ? UNIT_W'(1) : slot_unit_ff;

   // csr port, always ready
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   always_comb begin
      case (paddr[2])
         REG_SLOT_UNIT: prdata = {24'd0, slot_unit_ff};
         REG_COUNTDOWN: prdata = {16'd0, countdown_reload_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_unit_ff        <= SLOT_UNIT_RESET;
         countdown_reload_ff <= COUNTDOWN_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_SLOT_UNIT) begin
            slot_unit_ff <= pwdata[UNIT_W-1:0];
         end else begin
            countdown_reload_ff <= pwdata[COUNT_W-1:0];
         end
      end
   end

   // channel settings memory, read at the serve position on each transfer
   spsch_chan_mem #(
      .DEPTH (CHANNELS)
   ) u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (serve_ff),
      .rd_data (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // width / slot unit divider
   spsch_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   // sequencer; engine and pin state only change in the cycle the result is loaded
   always_comb begin
      logic                emit;
      logic                res_arm;
      logic                res_eng;
      logic [7:0]          res_reload;
      logic                res_pch_use;
      logic [CH_W-1:0]     res_pch;
      logic [1:0]          res_status;
      logic [CH_W-1:0]     serve_next;
      logic                eng_free;
      logic                exp_eng;
      logic [UNIT_W-1:0]   head;
      logic [PIN_W-1:0]    pin_ext;
      logic [PCH_W-1:0]    pch_ext;

      state_in     = state_ff;
      rq_type_in   = rq_type_ff;
      rq_ch_in     = rq_ch_ff;
      rq_en_in     = rq_en_ff;
      rq_width_in  = rq_width_ff;
      rq_cd_in     = rq_cd_ff;
      serve_in     = serve_ff;
      eng_busy_in  = eng_busy_ff;
      eng_ch_in    = eng_ch_ff;
      eng_slots_in = eng_slots_ff;
      pin_in       = pin_ff;
      rsp_pin_in    = rsp_pin_ff;
      rsp_arm_in    = rsp_arm_ff;
      rsp_eng_in    = rsp_eng_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_pch_in    = rsp_pch_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      emit        = 1'b0;
      res_arm     = 1'b0;
      res_eng     = 1'b0;
      res_reload  = '0;
      res_pch_use = 1'b0;
      res_pch     = serve_ff;
      res_status  = STATUS_OK;
      wr_en       = 1'b0;
      wr_addr     = serve_ff;
      wr_data     = rd_word;
      div_req.start    = 1'b0;
      div_req.dividend = rd_word.width;
      div_req.divisor  = unit_eff;

      serve_next = (serve_ff == CH_W'(CHANNELS - 1)) ? '0 : CH_W'(serve_ff + 1'b1);
      eng_free   = eng_busy_ff[0];
      exp_eng    = (rq_type_ff == REQ_EXP1);
      head       = div_res.remainder + unit_eff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rq_type_in  = req_type;
               rq_ch_in    = req_channel;
               rq_en_in    = req_enable;
               rq_width_in = req_pulse_width;
               rq_cd_in    = req_start_countdown;
               state_in    = (req_type == REQ_SLOT) ? ST_EVAL : ST_EXEC;
            end
         end
         // slot tick: decide on the served channel
         ST_EVAL: begin
            if (!rd_word.enable || rd_word.countdown != '0 || eng_busy_ff == 2'b11) begin
               if (out_free) begin
                  emit     = 1'b1;
                  serve_in = serve_next;
                  state_in = ST_IDLE;
                  if (rd_word.enable) begin
                     wr_en = 1'b1;
                     if (rd_word.countdown != '0) begin
                        wr_data.countdown = COUNT_W'(rd_word.countdown - 1'b1);
                     end else begin
                        wr_data.countdown = countdown_reload_ff;
                        res_pch_use       = 1'b1;
                        res_status        = STATUS_SKIP;
                     end
                  end
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_START;
            end
         end
         // pulse start on the first free engine
         ST_START: begin
            if (out_free) begin
               emit                  = 1'b1;
               serve_in              = serve_next;
               state_in              = ST_IDLE;
               wr_en                 = 1'b1;
               wr_data.countdown     = countdown_reload_ff;
               eng_busy_in[eng_free] = 1'b1;
               eng_ch_in[eng_free]   = serve_ff;
               eng_slots_in[eng_free] = (div_res.quotient == '0) ? '0
                                      : WIDTH_W'(div_res.quotient - 1'b1);
               pin_in[serve_ff]      = 1'b1;
               res_arm               = 1'b1;
               res_eng               = eng_free;
               res_reload            = ~head;
               res_pch_use           = 1'b1;
            end
         end
         // engine expiry or channel write
         ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (rq_type_ff == REQ_SET) begin
                  if (7'(rq_ch_ff) < 7'(CHANNELS)) begin
                     wr_en             = 1'b1;
                     wr_addr           = CH_W'(rq_ch_ff);
                     wr_data.enable    = rq_en_ff;
                     wr_data.width     = rq_width_ff;
                     wr_data.countdown = rq_cd_ff;
                  end
               end else if (!eng_busy_ff[exp_eng]) begin
                  res_status = STATUS_IDLE_EXP;
               end else begin
                  res_pch_use = 1'b1;
                  res_pch     = eng_ch_ff[exp_eng];
                  if (eng_slots_ff[exp_eng] == '0) begin
                     pin_in[eng_ch_ff[exp_eng]] = 1'b0;
                     eng_busy_in[exp_eng]       = 1'b0;
                  end else begin
                     eng_slots_in[exp_eng] = WIDTH_W'(eng_slots_ff[exp_eng] - 1'b1);
                     res_arm               = 1'b1;
                     res_eng               = exp_eng;
                     res_reload            = ~unit_eff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // load the result register
      pin_ext = PIN_W'(pin_in);
      pch_ext = PCH_W'(res_pch);
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_pin_in    = pin_ext[PIN_OUT_W-1:0];
         rsp_arm_in    = res_arm;
         rsp_eng_in    = res_eng;
         rsp_reload_in = res_reload;
         rsp_pch_in    = res_pch_use ? pch_ext[PCH_OUT_W-1:0] : '0;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         serve_ff        <= '0;
         eng_busy_ff     <= '0;
         eng_ch_ff[0]    <= '0;
         eng_ch_ff[1]    <= '0;
         eng_slots_ff[0] <= '0;
         eng_slots_ff[1] <= '0;
         pin_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         serve_ff     <= serve_in;
         eng_busy_ff  <= eng_busy_in;
         eng_ch_ff    <= eng_ch_in;
         eng_slots_ff <= eng_slots_in;
         pin_ff       <= pin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rq_type_ff    <= rq_type_in;
      rq_ch_ff      <= rq_ch_in;
      rq_en_ff      <= rq_en_in;
      rq_width_ff   <= rq_width_in;
      rq_cd_ff      <= rq_cd_in;
      rsp_pin_ff    <= rsp_pin_in;
      rsp_arm_ff    <= rsp_arm_in;
      rsp_eng_ff    <= rsp_eng_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_pch_ff    <= rsp_pch_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall         = reset || (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_levels    = rsp_pin_ff;
   assign rsp_arm_valid     = rsp_arm_ff;
   assign rsp_arm_engine    = rsp_eng_ff;
   assign rsp_reload_value  = rsp_reload_ff;
   assign rsp_pulse_channel = rsp_pch_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

`default_nettype wire

// ===== design/spsch_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spsch_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_pin_levels,
   input wire logic        rsp_arm_valid,
   input wire logic        rsp_arm_engine,
   input wire logic [7:0]  rsp_reload_value,
   input wire logic [3:0]  rsp_pulse_channel,
   input wire logic [1:0]  rsp_status
);
   import spsch_pkg::*;

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // one item in flight: a transfer closes the input side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted twice in a row");

   // no arm means no engine and no reload value
   a_no_arm_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_arm_valid) |-> (!rsp_arm_engine && rsp_reload_value == 8'd0))
      else $error("arm fields set without arm");

   // idle engine expiry reports no channel and arms nothing
   a_idle_expiry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_IDLE_EXP)
         |-> (!rsp_arm_valid && rsp_pulse_channel == 4'd0))
      else $error("idle expiry with channel or arm");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_pin_levels)
         && $stable(rsp_status) && $stable(rsp_reload_value)))
      else $error("stalled result changed");

endmodule

bind servo_pulse_scheduler spsch_checker u_spsch_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pin_levels    (rsp_pin_levels),
   .rsp_arm_valid     (rsp_arm_valid),
   .rsp_arm_engine    (rsp_arm_engine),
   .rsp_reload_value  (rsp_reload_value),
   .rsp_pulse_channel (rsp_pulse_channel),
   .rsp_status        (rsp_status)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import spsch_pkg::*;

   localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer before giving up
   localparam int SETTLE_CYCLES = 25;
   localparam int REPORT_MAX    = 10;

   // one input item and one result as seen on the ports
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  channel;
      logic        enable;
      logic [15:0] width;
      logic [15:0] countdown;
   } servo_cmd_type;

   typedef struct packed {
      logic [15:0] pin_levels;
      logic        arm_valid;
      logic        arm_engine;
      logic [7:0]  reload_value;
      logic [3:0]  pulse_channel;
      logic [1:0]  status;
   } servo_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_SLOT;
   logic [3:0]  req_channel = '0;
   logic        req_enable = 1'b0;
   logic [15:0] req_pulse_width = '0;
   logic [15:0] req_start_countdown = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [15:0] rsp_pin_levels;
   logic        rsp_arm_valid;
   logic        rsp_arm_engine;
   logic [7:0]  rsp_reload_value;
   logic [3:0]  rsp_pulse_channel;
   logic [1:0]  rsp_status;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // scheduler state mirrored by the testbench
   logic [7:0]  cfg_unit = SLOT_UNIT_RESET;
   logic [15:0] cfg_reload = COUNTDOWN_RESET;
   logic [15:0] ch_on = '0;
   logic [15:0] ch_width [16] = '{default: '0};
   logic [15:0] ch_wait [16] = '{default: '0};
   logic [3:0]  serve_ptr = '0;
   logic [1:0]  eng_busy = '0;
   logic [3:0]  eng_chan [2] = '{default: '0};
   logic [15:0] eng_left [2] = '{default: '0};
   logic [15:0] pins = '0;

   servo_result_type outputs_due [$];

   logic calm = 1'b0;  // no idling on either side
   int   error_count = 0;
   int   items_sent = 0;
   int   results_checked = 0;
   int   config_writes = 0;
   int   pulse_starts = 0;
   int   pulse_skips = 0;
   int   rearms = 0;
   int   idle_expiries = 0;
   int   idle_cycles = 0;
   int   hold_left = 0;

   servo_pulse_scheduler u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_channel         (req_channel),
      .req_enable          (req_enable),
      .req_pulse_width     (req_pulse_width),
      .req_start_countdown (req_start_countdown),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pin_levels      (rsp_pin_levels),
      .rsp_arm_valid       (rsp_arm_valid),
      .rsp_arm_engine      (rsp_arm_engine),
      .rsp_reload_value    (rsp_reload_value),
      .rsp_pulse_channel   (rsp_pulse_channel),
      .rsp_status          (rsp_status),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // advance the mirrored scheduler by one item and return its result
   function automatic servo_result_type schedule_step(input servo_cmd_type cmd);
      servo_result_type r;
      int unsigned unit, q, head;
      logic [3:0] ch;
      logic e;
      r = '0;
      unit = (cfg_unit == 0) ? 1 : cfg_unit;
      case (cmd.kind)
         REQ_SLOT: begin
            ch = serve_ptr;
            if (ch_on[ch]) begin
               if (ch_wait[ch] == 0) begin
                  ch_wait[ch] = cfg_reload;
                  r.pulse_channel = ch;
                  if (!eng_busy[0] || !eng_busy[1]) begin
                     // first free engine takes the pulse
                     e = eng_busy[0];
                     q = ch_width[ch] / unit;
                     head = ch_width[ch] % unit + unit;
                     eng_busy[e] = 1'b1;
                     eng_chan[e] = ch;
                     eng_left[e] = (q == 0) ? 16'd0 : 16'(q - 1);
                     pins[ch] = 1'b1;
                     r.arm_valid = 1'b1;
                     r.arm_engine = e;
                     r.reload_value = 8'(255 - (head & 255));
                  end else begin
                     r.status = STATUS_SKIP;
                  end
               end else begin
                  ch_wait[ch] = ch_wait[ch] - 16'd1;
               end
            end
            serve_ptr = ch + 4'd1;
         end
         REQ_EXP0, REQ_EXP1: begin
            e = (cmd.kind == REQ_EXP1);
            if (!eng_busy[e]) begin
               r.status = STATUS_IDLE_EXP;
            end else begin
               r.pulse_channel = eng_chan[e];
               if (eng_left[e] == 0) begin
                  pins[eng_chan[e]] = 1'b0;
                  eng_busy[e] = 1'b0;
               end else begin
                  eng_left[e] = eng_left[e] - 16'd1;
                  r.arm_valid = 1'b1;
                  r.arm_engine = e;
                  r.reload_value = 8'(255 - unit);
               end
            end
         end
         default: begin
            ch_on[cmd.channel] = cmd.enable;
            ch_width[cmd.channel] = cmd.width;
            ch_wait[cmd.channel] = cmd.countdown;
         end
      endcase
      r.pin_levels = pins;
      return r;
   endfunction

   // item of the given kind with random content in every other field
   function automatic servo_cmd_type cmd_of(input logic [1:0] kind);
      servo_cmd_type cmd;
      cmd.kind = kind;
      cmd.channel = 4'($urandom);
      cmd.enable = 1'($urandom);
      cmd.width = 16'($urandom);
      cmd.countdown = 16'($urandom);
      return cmd;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         note_mismatch(what, want, got);
   endtask

   // one transfer on the input channel, with an optional random gap before it
   task automatic send_cmd(input servo_cmd_type cmd);
      servo_result_type r;
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= cmd.kind;
      req_channel <= cmd.channel;
      req_enable <= cmd.enable;
      req_pulse_width <= cmd.width;
      req_start_countdown <= cmd.countdown;
      do @(posedge clock); while (req_stall);
      r = schedule_step(cmd);
      outputs_due.push_back(r);
      items_sent++;
      if (r.status == STATUS_SKIP) pulse_skips++;
      if (r.status == STATUS_IDLE_EXP) idle_expiries++;
      if (r.arm_valid && cmd.kind == REQ_SLOT) pulse_starts++;
      if (r.arm_valid && cmd.kind != REQ_SLOT) rearms++;
   endtask

   // program the served channel and tick it so that a pulse starts if an engine is free
   task automatic launch_pulse(input logic [15:0] width);
      servo_cmd_type cmd;
      cmd = cmd_of(REQ_SET);
      cmd.channel = serve_ptr;
      cmd.enable = 1'b1;
      cmd.width = width;
      cmd.countdown = '0;
      send_cmd(cmd);
      send_cmd(cmd_of(REQ_SLOT));
   endtask

   // expire running engines until both are idle
   task automatic drain_engines();
      while (eng_busy != 2'b00)
         send_cmd(cmd_of(eng_busy[0] ? REQ_EXP0 : REQ_EXP1));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write followed by a read back of the same register
   task automatic write_reg(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_SLOT_UNIT) ? 32'h0000_00FF : 32'h0000_FFFF;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field(idx == REG_SLOT_UNIT ? "slot_unit read back" : "countdown_reload read back",
                  value & mask, prdata & mask);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      config_writes++;
   endtask

   task automatic set_config(input logic [7:0] unit_sel, input logic [15:0] reload_sel);
      wait_idle();
      write_reg(REG_SLOT_UNIT, 32'(unit_sel));
      write_reg(REG_COUNTDOWN, 32'(reload_sel));
      cfg_unit = unit_sel;
      cfg_reload = reload_sel;
   endtask

   // expiries of idle engines and a tick on a disabled channel
   task automatic test_idle_expiry();
      send_cmd(cmd_of(REQ_EXP0));
      send_cmd(cmd_of(REQ_EXP1));
      send_cmd(cmd_of(REQ_SLOT));
   endtask

   // start, one rearm, end, and a countdown that only decrements
   task automatic test_pulse_lifecycle();
      servo_cmd_type cmd;
      launch_pulse(16'd250);
      send_cmd(cmd_of(REQ_EXP0));
      send_cmd(cmd_of(REQ_EXP0));
      cmd = cmd_of(REQ_SET);
      cmd.channel = serve_ptr;
      cmd.enable = 1'b1;
      cmd.width = 16'd300;
      cmd.countdown = 16'd2;
      send_cmd(cmd);
      send_cmd(cmd_of(REQ_SLOT));
   endtask

   // third pulse while both engines run is skipped
   task automatic test_engines_busy();
      repeat (3) launch_pulse(16'(cfg_unit));
      drain_engines();
   endtask

   // widest width on a disabled channel, zero width on an enabled one
   task automatic test_width_extremes();
      servo_cmd_type cmd;
      cmd = cmd_of(REQ_SET);
      cmd.enable = 1'b0;
      cmd.width = 16'hFFFF;
      cmd.countdown = 16'hFFFF;
      send_cmd(cmd);
      launch_pulse(16'd0);
      drain_engines();
   endtask

   // a slot unit of zero acts as one
   task automatic test_zero_slot_unit();
      set_config(8'd0, 16'd0);
      launch_pulse(16'd2);
      drain_engines();
   endtask

   // random traffic under one register setting, mostly well-formed pulse sequences
   task automatic test_random_traffic(input logic [7:0] unit_sel, input logic [15:0] reload_sel,
                                      input int count);
      servo_cmd_type cmd;
      int pick;
      int unsigned u;
      set_config(unit_sel, reload_sel);
      u = (cfg_unit == 0) ? 1 : cfg_unit;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         cmd = cmd_of(REQ_SLOT);
         if (pick >= 30 && pick < 60) begin
            // expiry, mostly on an engine that is running
            if (eng_busy != 2'b00 && $urandom_range(0, 9) != 0) begin
               if (eng_busy == 2'b11)
                  cmd.kind = $urandom_range(0, 1) ? REQ_EXP1 : REQ_EXP0;
               else
                  cmd.kind = eng_busy[0] ? REQ_EXP0 : REQ_EXP1;
            end else begin
               cmd.kind = $urandom_range(0, 1) ? REQ_EXP1 : REQ_EXP0;
            end
         end else if (pick >= 60 && pick < 88) begin
            // enabled channel with a short pulse, often the next one served
            cmd.kind = REQ_SET;
            if ($urandom_range(0, 1))
               cmd.channel = serve_ptr + 4'($urandom_range(0, 3));
            cmd.enable = 1'b1;
            cmd.width = 16'(u * $urandom_range(0, 4) + $urandom_range(0, u - 1));
            cmd.countdown = 16'($urandom_range(0, 3));
         end else if (pick >= 88) begin
            // disabled channel with arbitrary settings
            cmd.kind = REQ_SET;
            cmd.enable = 1'b0;
         end
         send_cmd(cmd);
      end
   endtask

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result transfer with the oldest outstanding prediction
   always @(posedge clock) begin : result_check
      servo_result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            note_mismatch("result with none outstanding", 32'd0, 32'(rsp_pin_levels));
         end else begin
            due = outputs_due.pop_front();
            results_checked++;
            check_field("pin_levels", due.pin_levels, rsp_pin_levels);
            check_field("arm_valid", due.arm_valid, rsp_arm_valid);
            check_field("arm_engine", due.arm_engine, rsp_arm_engine);
            check_field("reload_value", due.reload_value, rsp_reload_value);
            check_field("pulse_channel", due.pulse_channel, rsp_pulse_channel);
            check_field("status", due.status, rsp_status);
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_idle_expiry();
      test_pulse_lifecycle();
      test_engines_busy();
      test_width_extremes();
      test_zero_slot_unit();

      test_random_traffic(8'd255, 16'd0, 150);
      test_random_traffic(8'd1, 16'hFFFF, 150);
      repeat (3)
         test_random_traffic(8'($urandom_range(2, 254)), 16'($urandom_range(0, 3)), 150);
      calm <= 1'b1;
      test_random_traffic(8'($urandom_range(1, 255)), 16'($urandom_range(0, 2)), 150);

      // let the last results drain
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (outputs_due.size() != 0)
         note_mismatch("results never returned", 32'd0, 32'(outputs_due.size()));
      $display("covered %0d items, %0d results checked, %0d register writes",
               items_sent, results_checked, config_writes);
      $display("pulse starts %0d, rearms %0d, skipped pulses %0d, idle engine expiries %0d",
               pulse_starts, rearms, pulse_skips, idle_expiries);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
